>>> hdl/bea_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the bitmap extent allocator.
package bea_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] first_bit;
        logic [16:0] length;
        logic        bit_value;
        logic [16:0] want_zeros;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] result_value;
    } t_rsp;

    localparam logic [2:0] K_READ  = 3'd0;
    localparam logic [2:0] K_WRITE = 3'd1;
    localparam logic [2:0] K_COUNT = 3'd2;
    localparam logic [2:0] K_GAP   = 3'd3;
    localparam logic [2:0] K_GROW  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_ALL_ONES = 3'd3;
    localparam logic [2:0] ST_OZO      = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;      // clearing pass: write zero at the scan address
        logic start;    // load scan address from request
        logic rd;       // issue a memory read at the scan address
        logic wr;       // write the bit at the scan address
        logic step;     // advance the scan address
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic rbit;     // registered bit read
        logic clr_done; // scan address at its last entry
    } t_sts;

endpackage

>>> hdl/bea_datapath.sv
`timescale 1ns / 1ps
// Bitmap memory, bit addressed, with a scan address counter.
module bea_datapath #(
    parameter int MAP_BITS = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bea_pkg::t_cmd  i_cmd,
    input  logic [23:0]    i_addr,
    input  logic           i_wbit,
    output logic [23:0]    o_addr,
    output bea_pkg::t_sts  o_sts
);
    localparam int WORDS = (MAP_BITS + 7) / 8;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [7:0]  r_mem [WORDS];
    logic [7:0]  r_word;
    logic [2:0]  r_sel;
    logic [23:0] r_addr;
    logic [7:0]  n_word;

    assign o_addr = r_addr;
    assign o_sts.rbit = r_word[r_sel];
    assign o_sts.clr_done = (r_addr[AW-1:0] == AW'(WORDS - 1));

    // Read-modify-write of one bit uses the byte already read.
    always_comb begin
        n_word = r_word;
        n_word[r_addr[2:0]] = i_wbit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_addr[AW-1:0]] <= 8'h00;
        end else if (i_cmd.wr) begin
            r_mem[r_addr[AW+2:3]] <= n_word;
        end
        if (i_cmd.rd) begin
            r_word <= r_mem[r_addr[AW+2:3]];
            r_sel  <= r_addr[2:0];
        end else if (i_cmd.wr) begin
            r_word <= n_word;
        end
        // The clearing pass after reset starts at the first byte.
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.start) begin
            r_addr <= i_addr;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + 24'd1;
        end
    end
endmodule

>>> hdl/bea_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: argument checks, scans and result build.
module bea_ctrl #(
    parameter int MAP_BITS = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bea_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output bea_pkg::t_rsp  o_rsp,
    input  logic [16:0]    i_size,
    output bea_pkg::t_cmd  o_cmd,
    output logic [23:0]    o_addr,
    output logic           o_wbit,
    input  logic [23:0]    i_addr,
    input  bea_pkg::t_sts  i_sts
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EVAL, S_WR, S_DONE
    } t_state;

    t_state        r_state;
    bea_pkg::t_req r_req;
    logic [24:0]   r_cnt;     // bits examined so far
    logic [24:0]   r_lim;     // bits to examine
    logic [16:0]   r_run;
    logic [1:0]    r_phase;   // check grow: 0 first bit, 1 ones, 2 zeros, 3 zeros after a leading zero
    logic [2:0]    r_status;
    logic [16:0]   r_value;
    logic          r_valid;

    logic [24:0] w_size, w_end, w_clamp;
    logic        w_bad;
    logic [24:0] w_cnt1;
    logic        w_last;
    t_state      w_next;

    assign w_size = (25'(i_size) > 25'(MAP_BITS)) ? 25'(MAP_BITS) : 25'(i_size);
    assign w_end  = 25'(i_req.first_bit) + 25'(i_req.length);
    assign w_clamp = (w_end > w_size) ? w_size - 25'(i_req.first_bit) : 25'(i_req.length);
    assign w_cnt1 = r_cnt + 25'd1;
    assign w_last = (w_cnt1 == r_lim);
    assign w_next = w_last ? S_DONE : S_RD;

    always_comb begin
        w_bad = 1'b1;
        unique case (i_req.kind)
            bea_pkg::K_READ:  w_bad = !(25'(i_req.first_bit) < w_size);
            bea_pkg::K_WRITE: w_bad = w_end > w_size;
            bea_pkg::K_COUNT: w_bad = !(25'(i_req.first_bit) < w_size) || w_end > w_size;
            bea_pkg::K_GAP:   w_bad = !(25'(i_req.first_bit) < w_size)
                                || i_req.want_zeros == 17'd0 || i_req.length == 17'd0
                                || i_req.want_zeros > i_req.length;
            bea_pkg::K_GROW:  w_bad = !(25'(i_req.first_bit) < w_size)
                                || i_req.length == 17'd0 || w_end > w_size;
            default:          w_bad = 1'b1;
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.result_value = r_value;
    assign o_addr = 24'(i_req.first_bit);
    assign o_wbit = r_req.bit_value;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                o_cmd.step = 1'b1;
            end
            S_IDLE:  o_cmd.start = i_valid && !o_stall;
            S_RD:    o_cmd.rd = 1'b1;
            S_WR:    begin
                o_cmd.wr = 1'b1;
                o_cmd.step = 1'b1;
            end
            S_EVAL:  o_cmd.step = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != S_DONE) r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE: if (i_valid && !o_stall) begin
                    r_req <= i_req;
                    r_cnt <= '0;
                    r_run <= '0;
                    r_phase <= 2'd0;
                    r_value <= '0;
                    r_lim <= (i_req.kind == bea_pkg::K_GAP) ? w_clamp : 25'(i_req.length);
                    if (w_bad) begin
                        r_status <= bea_pkg::ST_BAD;
                        r_state <= S_DONE;
                    end else begin
                        r_status <= (i_req.kind == bea_pkg::K_GAP) ? bea_pkg::ST_MISS
                                                                    : bea_pkg::ST_OK;
                        if (i_req.kind != bea_pkg::K_READ && i_req.length == 17'd0)
                            r_state <= S_DONE;
                        else
                            r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: r_state <= (r_req.kind == bea_pkg::K_WRITE) ? S_WR : S_EVAL;
                S_WR: begin
                    r_cnt <= w_cnt1;
                    r_state <= w_next;
                end
                S_EVAL: begin
                    r_cnt <= w_cnt1;
                    case (r_req.kind)
                        bea_pkg::K_READ: begin
                            r_value <= 17'(i_sts.rbit);
                            r_state <= S_DONE;
                        end
                        bea_pkg::K_COUNT: begin
                            if (i_sts.rbit == r_req.bit_value) begin
                                r_value <= 17'(w_cnt1);
                                r_state <= w_next;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        bea_pkg::K_GAP: begin
                            if (!i_sts.rbit) begin
                                r_run <= r_run + 17'd1;
                                if (r_run + 17'd1 == r_req.want_zeros) begin
                                    r_status <= bea_pkg::ST_OK;
                                    r_value <= 17'(i_addr) + 17'd1 - r_req.want_zeros;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= w_next;
                                end
                            end else begin
                                r_run <= '0;
                                r_state <= w_next;
                            end
                        end
                        default: begin
                            // Check grow: ones, then zeros only; a leading zero needs all zeros.
                            if (r_phase == 2'd0) begin
                                r_state <= w_next;
                                if (i_sts.rbit) begin
                                    r_phase <= 2'd1;
                                    if (w_last) r_status <= bea_pkg::ST_ALL_ONES;
                                end else begin
                                    r_phase <= 2'd3;
                                end
                            end else if (r_phase == 2'd1) begin
                                r_state <= w_next;
                                if (!i_sts.rbit) r_phase <= 2'd2;
                                else if (w_last) r_status <= bea_pkg::ST_ALL_ONES;
                            end else if (i_sts.rbit) begin
                                r_status <= (r_phase == 2'd3) ? bea_pkg::ST_MISS
                                                              : bea_pkg::ST_OZO;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= w_next;
                            end
                        end
                    endcase
                end
                S_DONE: if (!r_valid || !i_stall) begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/bitmap_extent_allocator.sv
`timescale 1ns / 1ps
// Top level of the bitmap extent allocator.
// A request enters on i_valid/o_stall and is accepted when valid is high and
// stall low; one response leaves on o_valid/i_stall. The map size register
// is written on i_cfg_valid/o_cfg_ready; the user must write it only while
// the block is idle, which the block itself does not enforce. Each examined
// bit passes through a memory read, registered data, and evaluate or write,
// since the byte memory has one port. Bad arguments are answered without a
// scan. The response register holds a result while the receiver stalls; no
// new request is taken until the block is idle again. After reset a clearing
// pass writes zero to each of the (MAP_BITS+7)/8 memory bytes, one per cycle,
// and no request is accepted during it. The size register resets to 65536.
module bitmap_extent_allocator #(
    parameter int MAP_BITS = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bea_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output bea_pkg::t_rsp  o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [16:0]    i_cfg_data
);
    logic [16:0]   r_size;
    bea_pkg::t_cmd w_cmd;
    bea_pkg::t_sts w_sts;
    logic [23:0]   w_addr_in, w_addr;
    logic          w_wbit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= 17'd65536;
        else if (i_cfg_valid) r_size <= i_cfg_data;
    end

    bea_ctrl #(.MAP_BITS(MAP_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req, .o_valid, .i_stall, .o_rsp,
        .i_size(r_size), .o_cmd(w_cmd), .o_addr(w_addr_in), .o_wbit(w_wbit),
        .i_addr(w_addr), .i_sts(w_sts)
    );

    bea_datapath #(.MAP_BITS(MAP_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_addr(w_addr_in), .i_wbit(w_wbit),
        .o_addr(w_addr), .o_sts(w_sts)
    );
endmodule

>>> hdl/bea_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the allocator, bound to the top level.
module bea_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input bea_pkg::t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("response after reset");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= bea_pkg::ST_OZO)
        else $error("bad status code");
endmodule

bind bitmap_extent_allocator bea_checker u_chk (.*);
